// ===== sv/assert_macros.svh =====
// Assertion macros shared by the checking code of the scheduler block.
// Depends on nothing; the including module supplies clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SJF_CHECK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define SJF_CHECK_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== sv/sjf_pkg.sv =====
// Types, widths and state codes of the shortest-job-first timing block.
// Depends on nothing; every module of the block imports it.
package sjf_pkg;

   localparam int MAX_TASKS   = 32;
   localparam int TIME_BITS   = 16;
   localparam int IDX_W       = $clog2(MAX_TASKS);
   localparam int CNT_W       = $clog2(MAX_TASKS + 1);
   localparam int EXEC_W      = 16;
   localparam int ID_W        = 5;
   localparam int WT_W        = 21;
   localparam int AVG_W       = 29;
   localparam int RUN_W       = TIME_BITS + CNT_W;
   localparam int SUM_W       = TIME_BITS + 2 * CNT_W;
   localparam int DVD_W       = SUM_W + 8;
   localparam int DIV_CNT_W   = $clog2(DVD_W + 1);
   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

   typedef struct packed {
      logic [EXEC_W-1:0] exec_time;
      logic              last;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]  task_id;
      logic [WT_W-1:0]  wait_ticks;
      logic [WT_W-1:0]  turn_ticks;
      logic [AVG_W-1:0] avg_wait_x256;
      logic [AVG_W-1:0] avg_turnaround_x256;
      logic             overflow;
      logic             last_result;
   } rsp_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] time_val;
      logic [ID_W-1:0]      id;
   } entry_type;

   typedef struct packed {
      logic [ID_W-1:0]      id;
      logic [TIME_BITS-1:0] time_val;
      logic                 overflow;
      logic                 last;
   } task_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             busy;
   } front_status_type;

   typedef struct packed {
      logic             start;
      logic [SUM_W-1:0] sum_wait;
      logic [SUM_W-1:0] sum_turn;
      logic [CNT_W-1:0] count;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [AVG_W-1:0] avg_wait;
      logic [AVG_W-1:0] avg_turn;
   } div_rsp_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_SHIFT,
      F_PLACE,
      F_EMIT
   } front_state_type;

   typedef enum logic {
      B_RUN,
      B_DIV
   } back_state_type;

endpackage

// ===== sv/shortest_job_first_timing.sv =====
// Shortest-job-first timing block: top level joining front, queue and back.
// Depends on sjf_pkg, sjf_front, sjf_queue, sjf_back and assert_macros.svh.
//
// Usage: push one task a transaction on the req_ side (req_push while
// req_full is low), each with its execution time; the task marked last
// closes the set. Tasks are numbered by arrival from 0. While a task is
// being stored the front inserts it into a sorted store, one entry moved
// a cycle past every stored entry with a longer time; the first task of
// a set is written directly. After the last task the front streams the
// store in run order, reading each entry before pushing it, into a
// four-entry queue; the back turns each into a registered result once its
// output register is free. The final result of a set waits for the serial
// divider that forms both averages, one quotient bit a cycle.
// Results leave on the rsp_ side as a queue: the oldest waiting result is
// on rsp_data while rsp_empty is low and is taken when rsp_pop is high.
// A stalled receiver holds the output register; the back then stops, the
// queue fills and the front waits, and no result is lost.
// Tasks beyond the store's capacity are dropped and flag overflow on every
// result of their set. Reset empties the store, the queue and the output;
// the store needs no clearing pass, as only written entries are read.
`include "assert_macros.svh"

module shortest_job_first_timing
   import sjf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   logic             q_push;
   logic             q_full;
   task_type         q_in;
   logic             q_pop;
   logic             q_empty;
   task_type         q_out;
   front_status_type front_status;
   logic             avg_zero;
   logic             mid_result;

   // Accept tasks, sort them on arrival and stream them in run order.
   sjf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_push   (q_push),
      .q_item   (q_in),
      .q_full   (q_full),
      .status   (front_status)
   );

   // Decouple the two sides so each can stall on its own.
   sjf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .item_in  (q_in),
      .full     (q_full),
      .pop      (q_pop),
      .item_out (q_out),
      .empty    (q_empty)
   );

   // Accumulate times, divide for the averages and present results.
   sjf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .q_item    (q_out),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   assign avg_zero   = rsp_data.avg_wait_x256 == '0 && rsp_data.avg_turnaround_x256 == '0;
   assign mid_result = !rsp_empty && !rsp_data.last_result;

   `SJF_CHECK_ALWAYS(a_reset_empty, reset |=> rsp_empty, "result waiting after reset")
   `SJF_CHECK(a_count_bound, front_status.count <= CNT_W'(MAX_TASKS), "store count too big")
   `SJF_CHECK(a_avg_only_last, mid_result |-> avg_zero, "average off the last result")
   `SJF_CHECK(a_turn_ge_wait, !rsp_empty |-> (rsp_data.turn_ticks >= rsp_data.wait_ticks), "turn < wait")

endmodule

// ===== sv/sjf_front.sv =====
// Front part: takes tasks, keeps the store sorted by insertion, streams run order.
// Depends on sjf_pkg.
module sjf_front
   import sjf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  req_type          req_data,
   output logic             q_push,
   output task_type         q_item,
   input  logic             q_full,
   output front_status_type status
);

   front_state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             drop_ff, drop_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   entry_type        new_ff, new_in;
   logic             last_ff, last_in;
   logic [CNT_W-1:0] emit_ff, emit_in;
   logic             primed_ff, primed_in;

   entry_type        mem [MAX_TASKS];
   entry_type        rd_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;

   logic             accept;
   logic             room;
   logic             moves;
   logic             emit_last;
   entry_type        arrival;

   assign accept    = req_push && (state_ff == F_IDLE);
   assign room      = count_ff < CNT_W'(MAX_TASKS);
   assign moves     = rd_ff.time_val > new_ff.time_val;
   assign emit_last = CNT_W'(emit_ff + 1'b1) == count_ff;
   assign arrival   = '{time_val: TIME_BITS'(req_data.exec_time), id: ID_W'(count_ff)};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               if (room && count_ff != '0) begin
                  state_in = F_SHIFT;
               end else if (req_data.last) begin
                  state_in = F_EMIT;
               end
            end
         end
         F_SHIFT: begin
            if (moves && pos_ff == CNT_W'(1)) begin
               state_in = F_PLACE;
            end else if (!moves) begin
               state_in = last_ff ? F_EMIT : F_IDLE;
            end
         end
         F_PLACE: begin
            state_in = last_ff ? F_EMIT : F_IDLE;
         end
         F_EMIT: begin
            if (primed_ff && !q_full && emit_last) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_comb begin
      count_in  = count_ff;
      drop_in   = drop_ff;
      pos_in    = pos_ff;
      new_in    = new_ff;
      last_in   = last_ff;
      emit_in   = emit_ff;
      primed_in = primed_ff;
      rd_addr   = IDX_W'(count_ff - 1'b1);
      wr_en     = 1'b0;
      wr_addr   = IDX_W'(pos_ff);
      wr_data   = new_ff;
      q_push    = 1'b0;
      req_full  = (state_ff != F_IDLE);
      case (state_ff)
         F_IDLE: begin
            emit_in   = '0;
            primed_in = 1'b0;
            if (accept) begin
               last_in = req_data.last;
               new_in  = arrival;
               pos_in  = count_ff;
               if (room) begin
                  count_in = CNT_W'(count_ff + 1'b1);
                  if (count_ff == '0) begin
                     wr_en   = 1'b1;
                     wr_addr = '0;
                     wr_data = arrival;
                  end
               end else begin
                  drop_in = 1'b1;
               end
            end
         end
         F_SHIFT: begin
            rd_addr = IDX_W'(pos_ff - CNT_W'(2));
            wr_en   = 1'b1;
            if (moves) begin
               wr_data = rd_ff;
               pos_in  = CNT_W'(pos_ff - 1'b1);
            end
         end
         F_PLACE: begin
            wr_en = 1'b1;
         end
         F_EMIT: begin
            rd_addr = IDX_W'(emit_ff);
            if (primed_ff && !q_full) begin
               q_push    = 1'b1;
               emit_in   = CNT_W'(emit_ff + 1'b1);
               primed_in = 1'b0;
               if (emit_last) begin
                  count_in = '0;
                  drop_in  = 1'b0;
               end
            end else begin
               primed_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign q_item = '{id: rd_ff.id, time_val: rd_ff.time_val,
                     overflow: drop_ff, last: emit_last};
   assign status = '{count: count_ff, busy: req_full};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= F_IDLE;
         count_ff  <= '0;
         drop_ff   <= 1'b0;
         last_ff   <= 1'b0;
         emit_ff   <= '0;
         primed_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         drop_ff   <= drop_in;
         last_ff   <= last_in;
         emit_ff   <= emit_in;
         primed_ff <= primed_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      new_ff <= new_in;
   end

endmodule

// ===== sv/sjf_queue.sv =====
// Short queue of run-ordered tasks between the front and back parts.
// Depends on sjf_pkg.
module sjf_queue
   import sjf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  task_type item_in,
   output logic     full,
   input  logic     pop,
   output task_type item_out,
   output logic     empty
);

   task_type           slot_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ff, wr_in;
   logic [FIFO_AW-1:0] rd_ff, rd_in;
   logic [FIFO_AW:0]   fill_ff, fill_in;
   logic               do_push;
   logic               do_pop;

   assign full     = fill_ff == (FIFO_AW + 1)'(FIFO_DEPTH);
   assign empty    = fill_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign item_out = slot_ff[rd_ff];

   always_comb begin
      wr_in   = do_push ? FIFO_AW'(wr_ff + 1'b1) : wr_ff;
      rd_in   = do_pop ? FIFO_AW'(rd_ff + 1'b1) : rd_ff;
      fill_in = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = (FIFO_AW + 1)'(fill_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         fill_in = (FIFO_AW + 1)'(fill_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

endmodule

// ===== sv/sjf_div.sv =====
// Pair of bit-serial restoring dividers for the two averages of a set.
// Depends on sjf_pkg.
module sjf_div
   import sjf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0]     dvs_ff, dvs_in;
   logic [DVD_W-1:0]     a_ff, a_in, b_ff, b_in;
   logic [CNT_W-1:0]     ra_ff, ra_in, rb_ff, rb_in;
   logic [DVD_W-1:0]     a_step, b_step;
   logic [CNT_W-1:0]     ra_step, rb_step;

   // One restoring step: shift the top dividend bit into the remainder.
   function automatic logic [DVD_W+CNT_W-1:0] div_step(
      input logic [DVD_W-1:0] dvd,
      input logic [CNT_W-1:0] rem,
      input logic [CNT_W-1:0] dvs
   );
      logic [CNT_W:0] sh;
      logic           ge;
      logic [CNT_W:0] diff;
      sh   = {rem, dvd[DVD_W-1]};
      ge   = sh >= {1'b0, dvs};
      diff = sh - {1'b0, dvs};
      return {dvd[DVD_W-2:0], ge, ge ? diff[CNT_W-1:0] : sh[CNT_W-1:0]};
   endfunction

   assign {a_step, ra_step} = div_step(a_ff, ra_ff, dvs_ff);
   assign {b_step, rb_step} = div_step(b_ff, rb_ff, dvs_ff);

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      dvs_in  = dvs_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      ra_in   = ra_ff;
      rb_in   = rb_ff;
      if (req.start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = '0;
         dvs_in  = req.count;
         a_in    = {req.sum_wait, 8'd0};
         b_in    = {req.sum_turn, 8'd0};
         ra_in   = '0;
         rb_in   = '0;
      end else if (busy_ff) begin
         a_in   = a_step;
         b_in   = b_step;
         ra_in  = ra_step;
         rb_in  = rb_step;
         cnt_in = DIV_CNT_W'(cnt_ff + 1'b1);
         if (cnt_ff == DIV_CNT_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign rsp = '{done: done_ff, avg_wait: AVG_W'(a_ff), avg_turn: AVG_W'(b_ff)};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvs_ff <= dvs_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      ra_ff  <= ra_in;
      rb_ff  <= rb_in;
   end

endmodule

// ===== sv/sjf_back.sv =====
// Back part: accumulates waiting and turnaround times and presents results.
// Depends on sjf_pkg and sjf_div.
module sjf_back
   import sjf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     q_empty,
   output logic     q_pop,
   input  task_type q_item,
   output logic     rsp_empty,
   input  logic     rsp_pop,
   output rsp_type  rsp_data
);

   back_state_type   state_ff, state_in;
   logic [RUN_W-1:0] run_ff, run_in;
   logic [SUM_W-1:0] sumw_ff, sumw_in;
   logic [SUM_W-1:0] sumt_ff, sumt_in;
   logic [CNT_W-1:0] n_ff, n_in;
   rsp_type          out_ff, out_in;
   logic             out_valid_ff, out_valid_in;
   rsp_type          hold_ff, hold_in;

   div_req_type      div_req;
   div_rsp_type      div_rsp;

   logic             out_free;
   logic             take;
   logic [RUN_W-1:0] turn;
   logic [SUM_W-1:0] sumw_next;
   logic [SUM_W-1:0] sumt_next;
   rsp_type          res;

   sjf_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign out_free  = !out_valid_ff || rsp_pop;
   assign take      = (state_ff == B_RUN) && !q_empty && out_free;
   assign turn      = RUN_W'(run_ff + RUN_W'(q_item.time_val));
   assign sumw_next = SUM_W'(sumw_ff + SUM_W'(run_ff));
   assign sumt_next = SUM_W'(sumt_ff + SUM_W'(turn));
   assign res       = '{task_id: q_item.id, wait_ticks: WT_W'(run_ff),
                        turn_ticks: WT_W'(turn), avg_wait_x256: '0,
                        avg_turnaround_x256: '0, overflow: q_item.overflow,
                        last_result: q_item.last};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_RUN: begin
            if (take && q_item.last) begin
               state_in = B_DIV;
            end
         end
         B_DIV: begin
            if (div_rsp.done && out_free) begin
               state_in = B_RUN;
            end
         end
         default: state_in = B_RUN;
      endcase
   end

   always_comb begin
      run_in       = run_ff;
      sumw_in      = sumw_ff;
      sumt_in      = sumt_ff;
      n_in         = n_ff;
      hold_in      = hold_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      q_pop        = take;
      div_req      = '{start: 1'b0, sum_wait: sumw_next, sum_turn: sumt_next,
                       count: CNT_W'(n_ff + 1'b1)};
      case (state_ff)
         B_RUN: begin
            if (take) begin
               if (q_item.last) begin
                  div_req.start = 1'b1;
                  hold_in       = res;
                  run_in        = '0;
                  sumw_in       = '0;
                  sumt_in       = '0;
                  n_in          = '0;
               end else begin
                  out_in       = res;
                  out_valid_in = 1'b1;
                  run_in       = turn;
                  sumw_in      = sumw_next;
                  sumt_in      = sumt_next;
                  n_in         = CNT_W'(n_ff + 1'b1);
               end
            end
         end
         B_DIV: begin
            if (div_rsp.done && out_free) begin
               out_in                     = hold_ff;
               out_in.avg_wait_x256       = div_rsp.avg_wait;
               out_in.avg_turnaround_x256 = div_rsp.avg_turn;
               out_valid_in               = 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_RUN;
         run_ff       <= '0;
         sumw_ff      <= '0;
         sumt_ff      <= '0;
         n_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         run_ff       <= run_in;
         sumw_ff      <= sumw_in;
         sumt_ff      <= sumt_in;
         n_ff         <= n_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      hold_ff <= hold_in;
   end

endmodule

// ===== bench/shortest_job_first_timing_tb.sv =====
// Testbench of the shortest-job-first timing block: task sets in, run order out.
// Depends on sjf_pkg and the shortest_job_first_timing top level.
`timescale 1ns / 1ps

module shortest_job_first_timing_tb;
   import sjf_pkg::*;

   localparam int QUIET_LIMIT = 20000;

   logic    clock;
   logic    reset;
   logic    req_push;
   logic    req_full;
   req_type req_data;
   logic    rsp_empty;
   logic    rsp_pop;
   rsp_type rsp_data;

   shortest_job_first_timing DUT (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // Scheduler state held on the bench side: arrival times of the open set.
   logic [TIME_BITS-1:0] set_times[$];
   logic                 set_dropped;
   rsp_type              pending_results[$];

   int  error_count;
   int  quiet_cycles;
   bit  sink_stall_on;   // random idling of the receiver
   bit  source_gap_on;   // random idling of the sender
   bit  hold_sink;       // long receiver hold-off for the fill test

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Predict one accepted task: store it, and on the final one put the set
   // in run order and queue its results.
   task automatic schedule_task(input req_type item);
      int unsigned  order[$];
      int unsigned  n, j, p;
      logic [63:0]  run, sum_wait, sum_turn;
      rsp_type      r;
      begin
         if (set_times.size() < MAX_TASKS)
            set_times.push_back(item.exec_time[TIME_BITS-1:0]);
         else
            set_dropped = 1'b1;
         if (!item.last) return;
         n = set_times.size();
         // stable insertion sort: ties keep arrival order
         for (int i = 0; i < n; i++) begin
            j = order.size();
            while (j > 0 && set_times[order[j-1]] > set_times[i]) j--;
            order.insert(j, i);
         end
         run = 0;
         sum_wait = 0;
         sum_turn = 0;
         for (int k = 0; k < n; k++) begin
            p = order[k];
            r = '0;
            r.task_id     = p[ID_W-1:0];
            r.wait_ticks  = run[WT_W-1:0];
            r.turn_ticks  = WT_W'(run + set_times[p]);
            r.overflow    = set_dropped;
            r.last_result = (k == n - 1);
            sum_wait += run;
            sum_turn += run + set_times[p];
            run += set_times[p];
            if (k == n - 1) begin
               r.avg_wait_x256       = AVG_W'((sum_wait * 256) / n);
               r.avg_turnaround_x256 = AVG_W'((sum_turn * 256) / n);
            end
            pending_results.push_back(r);
         end
         set_times.delete();
         set_dropped = 1'b0;
      end
   endtask

   // Offer one task until the block takes it; random gaps come first.
   task automatic send_task(input logic [EXEC_W-1:0] t, input logic is_last);
      req_type item;
      begin
         item.exec_time = t;
         item.last      = is_last;
         if (source_gap_on && $urandom_range(0, 3) == 0) begin
            req_push <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
         req_push <= 1'b1;
         req_data <= item;
         @(posedge clock);
         while (req_full) @(posedge clock);
         schedule_task(item);
      end
   endtask

   // Send one set of n tasks; the last one closes it.
   task automatic send_set(input int n, input int max_t);
      for (int i = 0; i < n; i++)
         send_task(EXEC_W'($urandom_range(0, max_t)), i == n - 1);
   endtask

   // Drop the offer and wait until every expected result has come out.
   task automatic wait_drained();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Edge values, every bit of the time, ties and a lone task.
   task automatic test_directed();
      send_task(16'hFFFF, 1'b0);
      send_task(16'h0000, 1'b0);
      send_task(16'h5555, 1'b0);
      send_task(16'hAAAA, 1'b0);
      send_task(16'h5555, 1'b1);
      send_task(16'h1234, 1'b1);
      send_task(16'd7, 1'b0);
      send_task(16'd7, 1'b0);
      send_task(16'd7, 1'b1);
      wait_drained();
   endtask

   // Full store of maximum times overflowed through a dropped final task, then a full set of falling times.
   task automatic test_overflow();
      for (int i = 0; i < MAX_TASKS; i++) send_task(16'hFFFF, 1'b0);
      send_task(16'h0001, 1'b0);
      send_task(16'h0002, 1'b1);
      for (int i = 0; i < MAX_TASKS - 1; i++) send_task(EXEC_W'(16'hFFFF - i), 1'b0);
      send_task(16'h0000, 1'b1);
      wait_drained();
   endtask

   // Hold the receiver off while the sender keeps offering: the block fills.
   task automatic test_backpressure();
      hold_sink = 1'b1;
      fork
         begin
            repeat (2000) @(posedge clock);
            hold_sink = 1'b0;
         end
         begin
            send_set(MAX_TASKS, 65535);
            send_set(12, 255);
         end
      join
      wait_drained();
   endtask

   // Mostly small sets with random content; a few full or overflowing ones.
   task automatic test_random(input int items);
      int sent, n, sel;
      begin
         sent = 0;
         while (sent < items) begin
            sel = $urandom_range(0, 9);
            if (sel == 0) n = $urandom_range(MAX_TASKS, MAX_TASKS + 3);
            else n = $urandom_range(1, 8);
            send_set(n, (sel < 3) ? 15 : 65535);
            sent += n;
         end
         wait_drained();
      end
   endtask

   // Receiver: pop with random stalls, hold while told to.
   always @(posedge clock) begin
      if (reset)
         rsp_pop <= 1'b0;
      else if (hold_sink)
         rsp_pop <= 1'b0;
      else if (!sink_stall_on)
         rsp_pop <= 1'b1;
      else
         rsp_pop <= ($urandom_range(0, 3) != 0);
   end

   // Compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result task_id=%0d", rsp_data.task_id);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.task_id !== want.task_id) begin
               $error("task_id exp %0d got %0d", want.task_id, rsp_data.task_id);
               error_count++;
            end
            if (rsp_data.wait_ticks !== want.wait_ticks) begin
               $error("wait_ticks exp %0d got %0d", want.wait_ticks, rsp_data.wait_ticks);
               error_count++;
            end
            if (rsp_data.turn_ticks !== want.turn_ticks) begin
               $error("turn_ticks exp %0d got %0d", want.turn_ticks, rsp_data.turn_ticks);
               error_count++;
            end
            if (rsp_data.avg_wait_x256 !== want.avg_wait_x256) begin
               $error("avg_wait_x256 exp %0d got %0d",
                      want.avg_wait_x256, rsp_data.avg_wait_x256);
               error_count++;
            end
            if (rsp_data.avg_turnaround_x256 !== want.avg_turnaround_x256) begin
               $error("avg_turnaround_x256 exp %0d got %0d",
                      want.avg_turnaround_x256, rsp_data.avg_turnaround_x256);
               error_count++;
            end
            if (rsp_data.overflow !== want.overflow) begin
               $error("overflow exp %0d got %0d", want.overflow, rsp_data.overflow);
               error_count++;
            end
            if (rsp_data.last_result !== want.last_result) begin
               $error("last_result exp %0d got %0d",
                      want.last_result, rsp_data.last_result);
               error_count++;
            end
         end
      end
   end

   // Watchdog: count cycles with no transaction on either side.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      error_count   = 0;
      set_dropped   = 1'b0;
      hold_sink     = 1'b0;
      sink_stall_on = 1'b1;
      source_gap_on = 1'b1;
      reset    = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      rsp_pop  = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_overflow();
      test_backpressure();
      test_random(55);
      // last part of the run: no idling on either side
      sink_stall_on = 1'b0;
      source_gap_on = 1'b0;
      test_random(25);

      wait_drained();
      repeat (100) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== shortest_job_first_timing.f =====
+incdir+sv
sv/sjf_pkg.sv
sv/sjf_front.sv
sv/sjf_queue.sv
sv/sjf_div.sv
sv/sjf_back.sv
sv/shortest_job_first_timing.sv
bench/shortest_job_first_timing_tb.sv
